// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk and quiet in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define CHK_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- rtl/cbcw_pkg.sv -----
// ----------------------------------------------------------------------------
// cbcw_pkg
// widths, constants and types shared by the cubic window block
// ----------------------------------------------------------------------------
package cbcw_pkg;

	localparam int WINDOW_BITS = 20;
	localparam int FRAC_BITS   = 10;
	localparam int REG_FRAC    = 10;
	localparam int THRESH_BITS = WINDOW_BITS + FRAC_BITS;
	localparam int C_BITS      = 16;
	localparam int BETA_BITS   = 10;
	localparam int TIME_BITS   = 32;
	localparam int K_BITS      = 25;
	localparam int KIDX_BITS   = 5;
	localparam int MUL_W       = 96;
	localparam int MUL_B       = 32;
	localparam int DIGIT       = 8;

	localparam logic [WINDOW_BITS-1:0] WIN_MAX   = '1;
	localparam logic [K_BITS-1:0]      D_CAP     = K_BITS'(1) << 24;
	localparam logic [MUL_B-1:0]       NS_PER_S  = 32'd1000000000;
	localparam logic [THRESH_BITS-1:0] THRESH_MIN = THRESH_BITS'(1) << FRAC_BITS;

	// register indexes
	localparam logic [1:0] REG_CUBIC_C = 2'd0;
	localparam logic [1:0] REG_BETA    = 2'd1;
	localparam logic [1:0] REG_SSTHR   = 2'd2;

	// reset values
	localparam logic [C_BITS-1:0]      CUBIC_C_RST = 16'd410;
	localparam logic [BETA_BITS-1:0]   BETA_RST    = 10'd717;
	localparam logic [WINDOW_BITS-1:0] SSTHR_RST   = 20'd10000;

	// phase codes
	localparam logic [1:0] PH_SLOW   = 2'd0;
	localparam logic [1:0] PH_CUBIC  = 2'd1;
	localparam logic [1:0] PH_FRIEND = 2'd2;
	localparam logic [1:0] PH_LOSS   = 2'd3;

	typedef struct packed {
		logic             start;
		logic [MUL_W-1:0] a;
		logic [MUL_B-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [MUL_W-1:0] p;
	} mul_rsp_t;

	function automatic logic [WINDOW_BITS-1:0] inc_sat(input logic [WINDOW_BITS-1:0] v);
		return (v == WIN_MAX) ? WIN_MAX : v + 1'b1;
	endfunction

endpackage

// ----- rtl/cbcw_mul.sv -----
// ----------------------------------------------------------------------------
// cbcw_mul
// shared multiplier, one 8-bit digit of b per cycle into a 96-bit accumulator
// ----------------------------------------------------------------------------
module cbcw_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  cbcw_pkg::mul_req_t req,
	output cbcw_pkg::mul_rsp_t rsp
);
	import cbcw_pkg::*;

	logic             busy_q;
	logic             done_q;
	logic [MUL_W-1:0] a_q;
	logic [MUL_B-1:0] b_q;
	logic [MUL_W-1:0] acc_q;
	logic [MUL_W-1:0] part;

	assign part = a_q * MUL_W'(b_q[DIGIT-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && (b_q >> DIGIT) == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.a;
			b_q   <= req.b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + part;
			a_q   <= a_q << DIGIT;
			b_q   <= b_q >> DIGIT;
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.p    = acc_q;

endmodule

// ----- rtl/cubic_congestion_window.sv -----
// ----------------------------------------------------------------------------
// cubic_congestion_window
// cubic congestion window update, one event item in, one result item out
// ----------------------------------------------------------------------------
// Each accepted item is one event: a data arrival or a timeout, with a
// millisecond time stamp. The block holds the window, the slow start
// threshold, the last maximum window, the epoch start and an ack tally, and
// returns the window after the event with its phase. All products go through
// one shared 96-bit by 8-bit multiplier that takes one byte of its second
// operand per cycle, run under a small sequencer; in_stall is high from accept
// until the result is loaded into the output register. An arrival in
// congestion avoidance runs a 25-step bisection for K, each step three
// multiplies, then up to four more multiplies for the target compare. The
// output register lets a new item be accepted while the previous result
// still waits on out_stall.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cubic_congestion_window (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               func,
	input  logic [31:0]                        now_ms,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [cbcw_pkg::WINDOW_BITS-1:0]   window,
	output logic [1:0]                         phase,
	input  logic                               cfg_we,
	input  logic [1:0]                         cfg_index,
	input  logic [cbcw_pkg::WINDOW_BITS-1:0]   cfg_data
);
	import cbcw_pkg::*;

	// sequencer states
	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_DECIDE = 5'd1;
	localparam logic [4:0] S_WAIT   = 5'd2;
	localparam logic [4:0] S_TOFIN  = 5'd3;
	localparam logic [4:0] S_NB     = 5'd4;
	localparam logic [4:0] S_NC     = 5'd5;
	localparam logic [4:0] S_ND     = 5'd6;
	localparam logic [4:0] S_KA     = 5'd7;
	localparam logic [4:0] S_KB     = 5'd8;
	localparam logic [4:0] S_KC     = 5'd9;
	localparam logic [4:0] S_KD     = 5'd10;
	localparam logic [4:0] S_TT     = 5'd11;
	localparam logic [4:0] S_SA     = 5'd12;
	localparam logic [4:0] S_SB     = 5'd13;
	localparam logic [4:0] S_SC     = 5'd14;
	localparam logic [4:0] S_SD     = 5'd15;
	localparam logic [4:0] S_APPLY  = 5'd16;
	localparam logic [4:0] S_OUT    = 5'd17;

	// configuration
	logic [C_BITS-1:0]      cubic_c_q;
	logic [BETA_BITS-1:0]   beta_q;

	// window state
	logic [WINDOW_BITS-1:0] cur_window_q;
	logic [THRESH_BITS-1:0] slow_thresh_q;
	logic [WINDOW_BITS-1:0] max_window_q;
	logic [TIME_BITS-1:0]   epoch_start_q;
	logic                   epoch_active_q;
	logic [WINDOW_BITS-1:0] ack_tally_q;

	// sequencer and working registers
	logic [4:0]             state_q;
	logic [4:0]             ret_q;
	logic                   func_q;
	logic [TIME_BITS-1:0]   now_q;
	logic [MUL_W-1:0]       n_q;       // max_window*(1024-beta)*1e9
	logic [MUL_W-1:0]       s_q;       // |cur-max|*1024*1e9
	logic [K_BITS-1:0]      k_q;
	logic [KIDX_BITS-1:0]   bit_q;
	logic [K_BITS-1:0]      d_q;
	logic                   dir_lt_q;  // past K: friendly when c*d^3 below
	logic                   friendly_q;
	logic [1:0]             res_phase_q;

	// output register
	logic                   out_valid_q;
	logic [WINDOW_BITS-1:0] window_q;
	logic [1:0]             phase_q;

	mul_req_t mul_req;
	mul_rsp_t mul_rsp;

	logic [K_BITS-1:0]      cand;
	logic [TIME_BITS-1:0]   t_el;
	logic [TIME_BITS-1:0]   dk;
	logic [K_BITS-1:0]      d_new;
	logic [WINDOW_BITS-1:0] tally_inc;
	logic [WINDOW_BITS-1:0] to_window;
	logic [THRESH_BITS-1:0] to_thresh;

	assign cand      = k_q | (K_BITS'(1) << bit_q);
	assign t_el      = now_q - epoch_start_q;
	assign dk        = (t_el < TIME_BITS'(k_q)) ? TIME_BITS'(k_q) - t_el
		: t_el - TIME_BITS'(k_q);
	assign d_new     = (dk > TIME_BITS'(D_CAP)) ? D_CAP : dk[K_BITS-1:0];
	assign tally_inc = inc_sat(ack_tally_q);
	// timeout product window*beta; threshold keeps it in Q.10 since both scales match
	assign to_window = (mul_rsp.p[THRESH_BITS-1:REG_FRAC] == '0) ? WINDOW_BITS'(1)
		: mul_rsp.p[THRESH_BITS-1:REG_FRAC];
	assign to_thresh = (mul_rsp.p[THRESH_BITS-1:0] < THRESH_MIN) ? THRESH_MIN
		: mul_rsp.p[THRESH_BITS-1:0];

	// multiplier requests issued by the sequencer
	always_comb begin
		mul_req = '0;
		unique case (state_q)
			S_DECIDE: begin
				mul_req.start = func_q;
				mul_req.a     = MUL_W'(cur_window_q);
				mul_req.b     = MUL_B'(beta_q);
			end
			S_NB: begin
				mul_req.start = 1'b1;
				mul_req.a     = MUL_W'(max_window_q);
				mul_req.b     = MUL_B'(11'd1024 - 11'(beta_q));
			end
			S_NC: begin
				mul_req.start = 1'b1;
				mul_req.a     = mul_rsp.p;
				mul_req.b     = NS_PER_S;
			end
			S_KA: begin
				mul_req.start = 1'b1;
				mul_req.a     = MUL_W'(cand);
				mul_req.b     = MUL_B'(cand);
			end
			S_KB: begin
				mul_req.start = 1'b1;
				mul_req.a     = mul_rsp.p;
				mul_req.b     = MUL_B'(cand);
			end
			S_KC, S_SC: begin
				mul_req.start = 1'b1;
				mul_req.a     = mul_rsp.p;
				mul_req.b     = MUL_B'(cubic_c_q);
			end
			S_TT: begin
				// window gap scaled by 1024*1e9
				mul_req.start = 1'b1;
				mul_req.a     = (t_el < TIME_BITS'(k_q))
					? MUL_W'({max_window_q - cur_window_q, 10'b0})
					: MUL_W'({cur_window_q - max_window_q, 10'b0});
				mul_req.b     = NS_PER_S;
				if (t_el < TIME_BITS'(k_q)) begin
					if (max_window_q < cur_window_q) mul_req.start = 1'b0;
				end else begin
					if (cur_window_q <= max_window_q) mul_req.start = 1'b0;
				end
			end
			S_SA: begin
				mul_req.start = 1'b1;
				mul_req.a     = MUL_W'(d_q);
				mul_req.b     = MUL_B'(d_q);
			end
			S_SB: begin
				mul_req.start = 1'b1;
				mul_req.a     = mul_rsp.p;
				mul_req.b     = MUL_B'(d_q);
			end
			default: mul_req = '0;
		endcase
	end

	cbcw_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	// control and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			ret_q          <= S_IDLE;
			cubic_c_q      <= CUBIC_C_RST;
			beta_q         <= BETA_RST;
			cur_window_q   <= WINDOW_BITS'(1);
			slow_thresh_q  <= {SSTHR_RST, FRAC_BITS'(0)};
			max_window_q   <= '0;
			epoch_start_q  <= '0;
			epoch_active_q <= 1'b0;
			ack_tally_q    <= '0;
			out_valid_q    <= 1'b0;
			n_q            <= '0;
			s_q            <= '0;
			k_q            <= '0;
			bit_q          <= '0;
			d_q            <= '0;
			dir_lt_q       <= 1'b0;
			friendly_q     <= 1'b0;
			res_phase_q    <= PH_SLOW;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_OUT) out_valid_q <= 1'b0;

			if (cfg_we) begin
				unique case (cfg_index)
					REG_CUBIC_C: cubic_c_q <= cfg_data[C_BITS-1:0];
					REG_BETA:    beta_q    <= cfg_data[BETA_BITS-1:0];
					REG_SSTHR:   slow_thresh_q <= {cfg_data, FRAC_BITS'(0)};
					default:     ;
				endcase
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (func_q) begin
						ret_q   <= S_TOFIN;
						state_q <= S_WAIT;
					end else if ({cur_window_q, FRAC_BITS'(0)} < slow_thresh_q) begin
						cur_window_q <= inc_sat(cur_window_q);
						res_phase_q  <= PH_SLOW;
						state_q      <= S_OUT;
					end else begin
						// open a new epoch on the first avoidance arrival
						if (!epoch_active_q) begin
							epoch_active_q <= 1'b1;
							epoch_start_q  <= now_q;
							if (max_window_q < cur_window_q) max_window_q <= cur_window_q;
						end
						state_q <= S_NB;
					end
				end
				S_WAIT: begin
					if (mul_rsp.done) state_q <= ret_q;
				end
				S_TOFIN: begin
					max_window_q   <= cur_window_q;
					cur_window_q   <= to_window;
					slow_thresh_q  <= to_thresh;
					ack_tally_q    <= '0;
					epoch_active_q <= 1'b0;
					res_phase_q    <= PH_LOSS;
					state_q        <= S_OUT;
				end
				S_NB: begin
					ret_q   <= S_NC;
					state_q <= S_WAIT;
				end
				S_NC: begin
					ret_q   <= S_ND;
					state_q <= S_WAIT;
				end
				S_ND: begin
					n_q     <= mul_rsp.p;
					k_q     <= '0;
					bit_q   <= KIDX_BITS'(K_BITS - 1);
					state_q <= S_KA;
				end
				S_KA: begin
					ret_q   <= S_KB;
					state_q <= S_WAIT;
				end
				S_KB: begin
					ret_q   <= S_KC;
					state_q <= S_WAIT;
				end
				S_KC: begin
					ret_q   <= S_KD;
					state_q <= S_WAIT;
				end
				S_KD: begin
					// keep the candidate bit when c*cand^3 fits under n
					if (mul_rsp.p <= n_q) k_q <= cand;
					if (bit_q == '0) begin
						state_q <= S_TT;
					end else begin
						bit_q   <= bit_q - 1'b1;
						state_q <= S_KA;
					end
				end
				S_TT: begin
					d_q      <= d_new;
					dir_lt_q <= !(t_el < TIME_BITS'(k_q));
					if (mul_req.start) begin
						ret_q   <= S_SA;
						state_q <= S_WAIT;
					end else begin
						// before K above the max, or past K at or below it
						friendly_q <= (t_el < TIME_BITS'(k_q));
						state_q    <= S_APPLY;
					end
				end
				S_SA: begin
					s_q     <= mul_rsp.p;
					ret_q   <= S_SB;
					state_q <= S_WAIT;
				end
				S_SB: begin
					ret_q   <= S_SC;
					state_q <= S_WAIT;
				end
				S_SC: begin
					ret_q   <= S_SD;
					state_q <= S_WAIT;
				end
				S_SD: begin
					friendly_q <= dir_lt_q ? (mul_rsp.p < s_q) : (mul_rsp.p > s_q);
					state_q    <= S_APPLY;
				end
				S_APPLY: begin
					if (friendly_q) begin
						if (tally_inc >= cur_window_q) begin
							cur_window_q <= inc_sat(cur_window_q);
							ack_tally_q  <= '0;
						end else begin
							ack_tally_q  <= tally_inc;
						end
						res_phase_q <= PH_FRIEND;
					end else begin
						cur_window_q <= inc_sat(cur_window_q);
						res_phase_q  <= PH_CUBIC;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					// hand over once the output register is free
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			func_q <= func;
			now_q  <= now_ms;
		end
		if (state_q == S_OUT && (!out_valid_q || !out_stall)) begin
			window_q <= cur_window_q;
			phase_q  <= res_phase_q;
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign window    = window_q;
	assign phase     = phase_q;

	// window never drops to zero
	`CHK_IMPL(a_window_nonzero, 1'b1, cur_window_q != '0)
	// multiplier only finishes while the sequencer waits on it
	`CHK_IMPL(a_mul_done_in_wait, mul_rsp.done, state_q == S_WAIT)
	// an accepted item holds off the next one
	`CHK_NEXT(a_accept_stalls, in_valid && !in_stall, in_stall)

endmodule

// ----- verif/cubic_congestion_window_test.sv -----
// ----------------------------------------------------------------------------
// cubic_congestion_window_test
// self-checking bench for the cubic congestion window block
// ----------------------------------------------------------------------------
// A queue of event items is filled phase by phase. The registers are
// rewritten between phases, while the block is idle. A clocked driver offers
// the items with random gaps. A clocked monitor stalls at random and checks
// each result against a bit-exact window predictor kept in the bench.
// ----------------------------------------------------------------------------
module cubic_congestion_window_test;
	timeunit 1ns;
	timeprecision 1ps;
	import cbcw_pkg::*;

	localparam logic EV_DATA    = 1'b0;
	localparam logic EV_TIMEOUT = 1'b1;
	localparam logic [1:0] REG_NONE = 2'd3;   // index with no register behind it
	localparam int   SETTLE     = 600;   // cycles past the last result, well over one item

	typedef struct {
		logic        kind;
		logic [31:0] stamp;
	} event_t;

	typedef struct {
		logic [WINDOW_BITS-1:0] win;
		logic [1:0]             ph;
	} window_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic func = 1'b0;
	logic [31:0] now_ms = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [WINDOW_BITS-1:0] window;
	logic [1:0] phase;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = REG_CUBIC_C;
	logic [WINDOW_BITS-1:0] cfg_data = '0;

	cubic_congestion_window dut (.*);

	always #10 clk = ~clk;

	// items waiting to be offered, and windows waiting to come back
	event_t  pending_events[$];
	window_t expected_windows[$];
	int      events_queued = 0;
	int      windows_checked = 0;
	int      errors = 0;
	bit      quiet = 0;   // no idling on either side while set

	// predictor copy of the block's registers and state
	logic [C_BITS-1:0]      c_reg;
	logic [BETA_BITS-1:0]   beta_reg;
	logic [WINDOW_BITS-1:0] cwnd;
	logic [THRESH_BITS-1:0] ssthr;
	logic [WINDOW_BITS-1:0] wmax;
	logic [31:0]            epoch_t0;
	logic                   in_epoch;
	logic [WINDOW_BITS-1:0] acks;

	function automatic logic [127:0] c_times_cube(input logic [24:0] d);
		logic [127:0] x;
		x = 128'(d);
		return x * x * x * 128'(c_reg);
	endfunction

	function automatic logic [127:0] gap_scaled(input logic [WINDOW_BITS-1:0] v);
		logic [127:0] x;
		x = 128'(v);
		return x * 128'd1024 * 128'd1000000000;
	endfunction

	// cube root floored: largest k with c*k^3 <= wmax*(1024-beta)*1e9
	function automatic logic [24:0] k_millis();
		logic [127:0] lim;
		logic [24:0]  k;
		logic [24:0]  cand;
		lim = 128'(wmax) * 128'(11'd1024 - 11'(beta_reg)) * 128'd1000000000;
		k = '0;
		for (int b = 24; b >= 0; b--) begin
			cand = k | (25'd1 << b);
			if (c_times_cube(cand) <= lim)
				k = cand;
		end
		return k;
	endfunction

	function automatic logic [WINDOW_BITS-1:0] bump(input logic [WINDOW_BITS-1:0] v);
		return (v == WIN_MAX) ? WIN_MAX : v + 1'b1;
	endfunction

	task automatic predict_window(input event_t ev);
		logic [29:0] prod;
		logic [31:0] t;
		logic [24:0] k;
		logic [31:0] d;
		logic        friendly;
		window_t     r;
		if (ev.kind == EV_TIMEOUT) begin
			prod = 30'(cwnd) * 30'(beta_reg);
			wmax = cwnd;
			cwnd = prod[29:10];
			if (cwnd == '0)
				cwnd = WINDOW_BITS'(1);
			ssthr = (prod < THRESH_MIN) ? THRESH_MIN : prod;
			acks = '0;
			in_epoch = 1'b0;
			r.ph = PH_LOSS;
		end else if ((32'(cwnd) << FRAC_BITS) < 32'(ssthr)) begin
			cwnd = bump(cwnd);
			r.ph = PH_SLOW;
		end else begin
			if (!in_epoch) begin
				in_epoch = 1'b1;
				epoch_t0 = ev.stamp;
				if (wmax < cwnd)
					wmax = cwnd;
			end
			t = ev.stamp - epoch_t0;   // wraps when time runs backwards
			k = k_millis();
			if (t < 32'(k)) begin
				d = 32'(k) - t;
				if (d > 32'(D_CAP)) d = 32'(D_CAP);
				if (wmax < cwnd) friendly = 1'b1;
				else friendly = c_times_cube(d[24:0]) > gap_scaled(wmax - cwnd);
			end else begin
				d = t - 32'(k);
				if (d > 32'(D_CAP)) d = 32'(D_CAP);
				if (cwnd <= wmax) friendly = 1'b0;
				else friendly = c_times_cube(d[24:0]) < gap_scaled(cwnd - wmax);
			end
			if (friendly) begin
				acks = bump(acks);
				if (acks >= cwnd) begin
					cwnd = bump(cwnd);
					acks = '0;
				end
				r.ph = PH_FRIEND;
			end else begin
				cwnd = bump(cwnd);
				r.ph = PH_CUBIC;
			end
		end
		r.win = (cwnd == '0) ? WINDOW_BITS'(1) : cwnd;
		expected_windows.push_back(r);
	endtask

	task automatic report(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		errors++;
	endtask

	// driver: offers the next pending item after a random gap
	int send_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		logic   nv;
		event_t ev;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			nv = in_valid;
			if (in_valid && !in_stall) begin
				ev.kind = func;
				ev.stamp = now_ms;
				predict_window(ev);
				nv = 1'b0;
				send_gap = quiet ? 0 : $urandom_range(0, 16);
			end
			if (!nv) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_events.size() > 0) begin
					ev = pending_events.pop_front();
					func <= ev.kind;
					now_ms <= ev.stamp;
					nv = 1'b1;
				end
			end
			in_valid <= nv;
		end
	end

	// monitor: random stall per item, one long hold-off to fill the block
	int  recv_wait = 0;
	int  hold_off = 0;
	bit  held = 0;
	always @(posedge clk or negedge arst_n) begin
		window_t w;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_windows.size() == 0) begin
					report("result with nothing expected");
				end else begin
					w = expected_windows.pop_front();
					if (window !== w.win)
						report($sformatf("window %0d, expected %0d", window, w.win));
					if (phase !== w.ph)
						report($sformatf("phase %0d, expected %0d", phase, w.ph));
				end
				windows_checked++;
				recv_wait = quiet ? 0 : $urandom_range(0, 16);
				if (!held && windows_checked == 300) begin
					held = 1;
					hold_off = 2000;
				end
			end
			if (hold_off > 0) hold_off--;
			else if (recv_wait > 0) recv_wait--;
			out_stall <= (hold_off > 0) || (recv_wait > 0);
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [WINDOW_BITS-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_CUBIC_C: c_reg = val[C_BITS-1:0];
			REG_BETA: beta_reg = val[BETA_BITS-1:0];
			REG_SSTHR: ssthr = THRESH_BITS'(val) << FRAC_BITS;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_event(input logic kind, input logic [31:0] stamp);
		event_t ev;
		ev.kind = kind;
		ev.stamp = stamp;
		pending_events.push_back(ev);
		events_queued++;
	endtask

	// wait for all results, then for the block to go quiet
	task automatic drain();
		while (windows_checked != events_queued || expected_windows.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// mostly well-formed growth runs with rising time, some losses and noise
	task automatic random_burst(input int n, inout logic [31:0] clock_ms);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				queue_event(EV_TIMEOUT, $urandom());
			end else if (r < 12) begin
				clock_ms = $urandom();   // jump anywhere, backwards too
				queue_event(EV_DATA, clock_ms);
			end else begin
				clock_ms += $urandom_range(0, (r < 20) ? 3000 : 200);
				queue_event(EV_DATA, clock_ms);
			end
		end
	endtask

	initial begin
		logic [31:0] clock_ms;
		c_reg = CUBIC_C_RST;
		beta_reg = BETA_RST;
		ssthr = THRESH_BITS'(SSTHR_RST) << FRAC_BITS;
		cwnd = WINDOW_BITS'(1);
		wmax = '0;
		epoch_t0 = '0;
		in_epoch = 1'b0;
		acks = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// reset settings: slow start, losses, time stamps at both ends
		quiet = 1;
		queue_event(EV_DATA, 32'd0);
		queue_event(EV_DATA, 32'hFFFF_FFFF);
		queue_event(EV_TIMEOUT, 32'd0);
		queue_event(EV_TIMEOUT, 32'hFFFF_FFFF);
		queue_event(EV_DATA, 32'd5);
		drain();

		// zero cubic constant, zero beta, zero threshold: slow start skipped
		quiet = 0;
		write_reg(REG_CUBIC_C, 20'd0);
		write_reg(REG_BETA, 20'd0);
		write_reg(REG_SSTHR, 20'd0);
		write_reg(REG_NONE, 20'hFFFFF);   // unused index, no effect
		queue_event(EV_DATA, 32'd0);       // epoch opens at time zero
		queue_event(EV_DATA, 32'd100);
		queue_event(EV_TIMEOUT, 32'd200);  // window falls to its floor
		queue_event(EV_DATA, 32'd300);
		queue_event(EV_DATA, 32'd299);     // time running backwards
		queue_event(EV_DATA, 32'hFFFF_FFFF);
		drain();

		// top extremes of every register
		write_reg(REG_CUBIC_C, 20'h0FFFF);
		write_reg(REG_BETA, 20'h003FF);
		write_reg(REG_SSTHR, 20'hFFFFF);
		for (int i = 0; i < 4; i++)
			queue_event(EV_DATA, 32'(i * 1000));
		queue_event(EV_TIMEOUT, 32'd5000);
		drain();
		write_reg(REG_SSTHR, 20'd1);

		// small threshold, so cubic and friendly regions come fast
		write_reg(REG_SSTHR, 20'd4);
		write_reg(REG_CUBIC_C, 20'd1);
		write_reg(REG_BETA, 20'd512);
		queue_event(EV_DATA, 32'd0);
		for (int i = 1; i < 8; i++)
			queue_event(EV_DATA, 32'(i * 400));
		queue_event(EV_TIMEOUT, 32'd4000);
		for (int i = 0; i < 4; i++)
			queue_event(EV_DATA, 32'(4000 + i * 10));
		drain();

		// random phases with fresh settings each time
		clock_ms = 32'd1000;
		for (int p = 0; p < 8; p++) begin
			quiet = (p == 3);
			case ($urandom_range(0, 3))
				0: write_reg(REG_CUBIC_C, 20'(CUBIC_C_RST));
				1: write_reg(REG_CUBIC_C, 20'($urandom_range(0, 65535)));
				2: write_reg(REG_CUBIC_C, 20'($urandom_range(1, 2000)));
				default: write_reg(REG_CUBIC_C, (p & 1) ? 20'd0 : 20'h0FFFF);
			endcase
			case ($urandom_range(0, 3))
				0: write_reg(REG_BETA, 20'(BETA_RST));
				1: write_reg(REG_BETA, 20'($urandom_range(0, 1023)));
				2: write_reg(REG_BETA, 20'($urandom_range(300, 900)));
				default: write_reg(REG_BETA, (p & 2) ? 20'd0 : 20'h003FF);
			endcase
			if ($urandom_range(0, 5) == 0)
				write_reg(REG_SSTHR, 20'($urandom()));
			else
				write_reg(REG_SSTHR, 20'($urandom_range(0, 40)));
			random_burst(135, clock_ms);
			drain();
		end

		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// guard against a hung handshake
	initial begin
		#100ms;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
